// ===== hdl/rucs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rucs_pkg
// shared types and constants of the range unimodal check engine
// ----------------------------------------------------------------------------
package rucs_pkg;

  localparam int VAL_W = 30;
  localparam int IDX_W = 11;
  localparam int CNT_W = 10;
  localparam int EC_W  = 11;
  localparam logic [EC_W-1:0] EC_RESET = 11'd1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_LD_WR,
    S_UP_RD,
    S_UP_WR,
    S_PK_RD,
    S_PK_AC,
    S_CT_SET,
    S_CT_RD,
    S_CT_AC
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/rucs_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rucs_cfg
// apb register block holding element_count
// ----------------------------------------------------------------------------
module rucs_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [1:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [rucs_pkg::EC_W-1:0]      elem_count
);
  import rucs_pkg::*;

  logic [EC_W-1:0] count_r;
  logic            wr_en;

  // single register: every word address decodes to it
  assign wr_en  = psel && penable && pwrite && (paddr == paddr);
  assign pready = 1'b1;
  assign prdata = {{(32-EC_W){1'b0}}, count_r};
  assign elem_count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= EC_RESET;
    end else if (wr_en) begin
      count_r <= pwdata[EC_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rucs_tree_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rucs_tree_ram
// node memory of the range tree, one write and two registered reads a cycle
// ----------------------------------------------------------------------------
module rucs_tree_ram #(
  parameter int DW = 63,
  parameter int AW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr0,
  input  wire logic [AW-1:0] raddr1,
  output logic [DW-1:0]      rdata0,
  output logic [DW-1:0]      rdata1
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// ===== hdl/rucs_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rucs_seq
// sequencer: tree clear, leaf update walk and the three query walks
// ----------------------------------------------------------------------------
module rucs_seq #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int PW = $clog2(MAX_ELEMENTS + 1),
  parameter int NW = $clog2(2 * MAX_ELEMENTS),
  parameter int DW = 30 + 3 * PW
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          mode,
  input  wire logic [rucs_pkg::VAL_W-1:0]    element_value,
  input  wire logic [rucs_pkg::IDX_W-1:0]    element_index,
  input  wire logic [rucs_pkg::IDX_W-1:0]    query_left,
  input  wire logic [rucs_pkg::IDX_W-1:0]    query_right,
  input  wire logic [rucs_pkg::EC_W-1:0]     elem_count,
  output logic                               busy,
  output logic                               res_valid,
  output logic                               res_ladder,
  output logic [rucs_pkg::IDX_W-1:0]         res_index,
  output logic [rucs_pkg::VAL_W-1:0]         res_value,
  output logic [rucs_pkg::CNT_W-1:0]         res_falls,
  output logic [rucs_pkg::CNT_W-1:0]         res_rises,
  output logic                               t_we,
  output logic [NW-1:0]                      t_waddr,
  output logic [DW-1:0]                      t_wdata,
  output logic [NW-1:0]                      t_raddr0,
  output logic [NW-1:0]                      t_raddr1,
  input  wire logic [DW-1:0]                 t_rdata0,
  input  wire logic [DW-1:0]                 t_rdata1
);
  import rucs_pkg::*;

  localparam int XW  = (PW > IDX_W) ? PW : IDX_W;
  localparam int HW  = PW + 1;
  localparam int VAW = $clog2(MAX_ELEMENTS);
  localparam int LAST_NODE = 2 * MAX_ELEMENTS - 1;

  function automatic logic beats(input logic [VAL_W-1:0] v, input logic [PW-1:0] p,
                                 input logic [VAL_W-1:0] bv, input logic [PW-1:0] bp);
    beats = (v > bv) || ((v == bv) && (p > bp));
  endfunction

  state_t state_r, state_nxt;
  logic [NW:0]      a_r, a_nxt, b_r, b_nxt;
  logic [NW-1:0]    k_r, k_nxt;
  logic [NW-1:0]    clr_r, clr_nxt;
  logic [VAL_W-1:0] bv_r, bv_nxt, val_r, val_nxt;
  logic [PW-1:0]    bp_r, bp_nxt, s_r, s_nxt, falls_r, falls_nxt;
  logic [PW-1:0]    left_r, left_nxt, right_r, right_nxt, pos_r, pos_nxt;
  logic             phase_r, phase_nxt, oa_r, oa_nxt, ob_r, ob_nxt;
  logic             ov_r, ov_nxt, ol_r, ol_nxt;
  logic [PW-1:0]    oi_r, oi_nxt, of_r, of_nxt, or_r, or_nxt;
  logic [VAL_W-1:0] ovl_r, ovl_nxt;

  // value store, no reset
  logic [VAL_W-1:0] vmem [MAX_ELEMENTS];
  logic [VAL_W-1:0] vrd;
  logic [VAW-1:0]   vraddr;
  logic             vwe;
  logic [VAW-1:0]   vwaddr;

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwaddr] <= val_r;
    end
    vrd <= vmem[vraddr];
  end

  // input decode
  logic [XW-1:0] posx, cntx, lx, rx;
  logic          pos_ok, q_empty;

  assign posx = XW'(element_index);
  assign pos_ok = (posx >= XW'(1)) && (posx <= XW'(MAX_ELEMENTS));
  always_comb begin
    cntx = XW'(elem_count);
    if (cntx > XW'(MAX_ELEMENTS)) cntx = XW'(MAX_ELEMENTS);
    lx = XW'(query_left);
    if (lx == '0) lx = XW'(1);
    rx = XW'(query_right);
    if (rx > cntx) rx = cntx;
  end
  assign q_empty = lx > rx;

  // node fields
  logic [VAL_W-1:0] v0, v1;
  logic [PW-1:0]    p0, p1, r0, r1, f0, f1;
  assign v0 = t_rdata0[DW-1 -: VAL_W];
  assign p0 = t_rdata0[3*PW-1 -: PW];
  assign r0 = t_rdata0[2*PW-1 -: PW];
  assign f0 = t_rdata0[PW-1:0];
  assign v1 = t_rdata1[DW-1 -: VAL_W];
  assign p1 = t_rdata1[3*PW-1 -: PW];
  assign r1 = t_rdata1[2*PW-1 -: PW];
  assign f1 = t_rdata1[PW-1:0];

  logic        a_lt_b;
  logic [NW:0] leaf;
  assign a_lt_b = a_r < b_r;
  assign leaf = (NW+1)'(MAX_ELEMENTS) + (NW+1)'(pos_r) - (NW+1)'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:    if (clr_r == NW'(LAST_NODE)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (!mode) state_nxt = pos_ok ? S_LD_WR : S_IDLE;
          else       state_nxt = q_empty ? S_IDLE : S_PK_RD;
        end
      end
      S_LD_WR:  state_nxt = S_UP_RD;
      S_UP_RD:  state_nxt = S_UP_WR;
      S_UP_WR:  state_nxt = (k_r == NW'(1)) ? S_IDLE : S_UP_RD;
      S_PK_RD:  state_nxt = a_lt_b ? S_PK_AC : S_CT_SET;
      S_PK_AC:  state_nxt = S_PK_RD;
      S_CT_SET: state_nxt = S_CT_RD;
      S_CT_RD:  state_nxt = a_lt_b ? S_CT_AC : (phase_r ? S_IDLE : S_CT_SET);
      S_CT_AC:  state_nxt = S_CT_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath
  logic [HW-1:0]    lo, hi;
  logic             rng_ok;
  logic [VAL_W-1:0] tv;
  logic [PW-1:0]    tp, add0, add1;
  logic             rise, fall;

  always_comb begin
    a_nxt = a_r;  b_nxt = b_r;  k_nxt = k_r;  clr_nxt = clr_r;
    bv_nxt = bv_r;  bp_nxt = bp_r;  s_nxt = s_r;  falls_nxt = falls_r;
    left_nxt = left_r;  right_nxt = right_r;  pos_nxt = pos_r;  val_nxt = val_r;
    phase_nxt = phase_r;  oa_nxt = oa_r;  ob_nxt = ob_r;
    ov_nxt = 1'b0;  ol_nxt = ol_r;  oi_nxt = oi_r;  ovl_nxt = ovl_r;
    of_nxt = of_r;  or_nxt = or_r;
    t_we = 1'b0;  t_waddr = '0;  t_wdata = '0;
    t_raddr0 = a_r[NW-1:0];  t_raddr1 = NW'(b_r - (NW+1)'(1));
    vwe = 1'b0;  vwaddr = VAW'(pos_r - PW'(1));
    vraddr = VAW'(posx - XW'(2));
    lo = '0;  hi = '0;  rng_ok = 1'b0;
    tv = bv_r;  tp = bp_r;  add0 = '0;  add1 = '0;
    rise = 1'b0;  fall = 1'b0;
    case (state_r)
      S_CLR: begin
        t_we = 1'b1;
        t_waddr = clr_r;
        clr_nxt = clr_r + NW'(1);
      end
      S_IDLE: begin
        if (start) begin
          pos_nxt = PW'(posx);
          val_nxt = element_value;
          if (mode) begin
            if (q_empty) begin
              ov_nxt = 1'b1;  ol_nxt = 1'b0;  oi_nxt = '0;  ovl_nxt = '0;
              of_nxt = '0;  or_nxt = '0;
            end else begin
              left_nxt = PW'(lx);
              right_nxt = PW'(rx);
              a_nxt = (NW+1)'(MAX_ELEMENTS) + (NW+1)'(lx) - (NW+1)'(1);
              b_nxt = (NW+1)'(MAX_ELEMENTS) + (NW+1)'(rx);
              bv_nxt = '0;
              bp_nxt = '0;
            end
          end
        end
      end
      S_LD_WR: begin
        // first position is always flat
        if (pos_r > PW'(1)) begin
          rise = val_r > vrd;
          fall = val_r < vrd;
        end
        vwe = 1'b1;
        t_we = 1'b1;
        t_waddr = leaf[NW-1:0];
        t_wdata = {val_r, pos_r, PW'(rise), PW'(fall)};
        k_nxt = leaf[NW:1];
      end
      S_UP_RD: begin
        t_raddr0 = {k_r[NW-2:0], 1'b0};
        t_raddr1 = {k_r[NW-2:0], 1'b1};
      end
      S_UP_WR: begin
        t_we = 1'b1;
        t_waddr = k_r;
        if (beats(v0, p0, v1, p1)) t_wdata = {v0, p0, r0 + r1, f0 + f1};
        else                       t_wdata = {v1, p1, r0 + r1, f0 + f1};
        k_nxt = k_r >> 1;
      end
      S_PK_RD, S_CT_RD: begin
        if (a_lt_b) begin
          oa_nxt = a_r[0];
          ob_nxt = b_r[0];
          a_nxt = (a_r + (NW+1)'(a_r[0])) >> 1;
          b_nxt = (b_r - (NW+1)'(b_r[0])) >> 1;
        end else if (state_r == S_PK_RD) begin
          phase_nxt = 1'b0;
        end else if (!phase_r) begin
          falls_nxt = s_r;
          phase_nxt = 1'b1;
        end else begin
          ov_nxt = 1'b1;
          ol_nxt = (falls_r == '0) && (s_r == '0);
          oi_nxt = bp_r;
          ovl_nxt = bv_r;
          of_nxt = falls_r;
          or_nxt = s_r;
        end
      end
      S_PK_AC: begin
        // left node is merged before right node
        if (oa_r && beats(v0, p0, tv, tp)) begin
          tv = v0;  tp = p0;
        end
        if (ob_r && beats(v1, p1, tv, tp)) begin
          tv = v1;  tp = p1;
        end
        bv_nxt = tv;
        bp_nxt = tp;
      end
      S_CT_SET: begin
        if (!phase_r) begin
          lo = HW'(left_r) + HW'(1);
          hi = HW'(bp_r);
        end else begin
          lo = HW'(bp_r) + HW'(1);
          hi = HW'(right_r);
        end
        rng_ok = (lo >= HW'(1)) && (lo <= hi) && (hi <= HW'(MAX_ELEMENTS));
        s_nxt = '0;
        if (rng_ok) begin
          a_nxt = (NW+1)'(MAX_ELEMENTS) + (NW+1)'(lo) - (NW+1)'(1);
          b_nxt = (NW+1)'(MAX_ELEMENTS) + (NW+1)'(hi);
        end else begin
          a_nxt = '0;
          b_nxt = '0;
        end
      end
      S_CT_AC: begin
        if (oa_r) add0 = phase_r ? r0 : f0;
        if (ob_r) add1 = phase_r ? r1 : f1;
        s_nxt = s_r + add0 + add1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;  b_r <= b_nxt;  k_r <= k_nxt;
    bv_r <= bv_nxt;  bp_r <= bp_nxt;  s_r <= s_nxt;  falls_r <= falls_nxt;
    left_r <= left_nxt;  right_r <= right_nxt;  pos_r <= pos_nxt;  val_r <= val_nxt;
    oa_r <= oa_nxt;  ob_r <= ob_nxt;
    ol_r <= ol_nxt;  oi_r <= oi_nxt;  ovl_r <= ovl_nxt;  of_r <= of_nxt;  or_r <= or_nxt;
  end

  logic [XW-1:0] oix, ofx, orx;
  assign oix = XW'(oi_r);
  assign ofx = XW'(of_r);
  assign orx = XW'(or_r);

  assign busy       = (state_r != S_IDLE);
  assign res_valid  = ov_r;
  assign res_ladder = ol_r;
  assign res_index  = oix[IDX_W-1:0];
  assign res_value  = ovl_r;
  assign res_falls  = ofx[CNT_W-1:0];
  assign res_rises  = orx[CNT_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/range_unimodal_check_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// range_unimodal_check_engine
// range maximum tree with rise and fall counts, answers ladder queries
// ----------------------------------------------------------------------------
// load: leaf write, then a node update walk of a read and a write state per tree level
// query: three tree walks (peak, falls, rises), a read and an accumulate state per
//   level through the two-port node memory; an empty range answers the next cycle
// one request at a time, busy high while it runs; results are one-cycle strobes
// reset: clearing pass over 2*MAX_ELEMENTS tree nodes, busy high until done
module range_unimodal_check_engine #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_mode,
  input  wire logic [rucs_pkg::VAL_W-1:0]    in_element_value,
  input  wire logic [rucs_pkg::IDX_W-1:0]    in_element_index,
  input  wire logic [rucs_pkg::IDX_W-1:0]    in_query_left,
  input  wire logic [rucs_pkg::IDX_W-1:0]    in_query_right,
  output logic                               out_valid,
  output logic                               out_is_ladder,
  output logic [rucs_pkg::IDX_W-1:0]         out_peak_index,
  output logic [rucs_pkg::VAL_W-1:0]         out_peak_value,
  output logic [rucs_pkg::CNT_W-1:0]         out_falls_before_peak,
  output logic [rucs_pkg::CNT_W-1:0]         out_rises_after_peak,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [1:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import rucs_pkg::*;

  localparam int PW = $clog2(MAX_ELEMENTS + 1);
  localparam int NW = $clog2(2 * MAX_ELEMENTS);
  localparam int DW = VAL_W + 3 * PW;

  logic [EC_W-1:0] elem_count;
  logic            t_we;
  logic [NW-1:0]   t_waddr, t_raddr0, t_raddr1;
  logic [DW-1:0]   t_wdata, t_rdata0, t_rdata1;

  rucs_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .elem_count(elem_count)
  );

  rucs_tree_ram #(.DW(DW), .AW(NW)) u_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr0(t_raddr0), .raddr1(t_raddr1), .rdata0(t_rdata0), .rdata1(t_rdata1)
  );

  rucs_seq #(.MAX_ELEMENTS(MAX_ELEMENTS), .PW(PW), .NW(NW), .DW(DW)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .mode(in_mode),
    .element_value(in_element_value), .element_index(in_element_index),
    .query_left(in_query_left), .query_right(in_query_right),
    .elem_count(elem_count), .busy(busy),
    .res_valid(out_valid), .res_ladder(out_is_ladder), .res_index(out_peak_index),
    .res_value(out_peak_value), .res_falls(out_falls_before_peak),
    .res_rises(out_rises_after_peak),
    .t_we(t_we), .t_waddr(t_waddr), .t_wdata(t_wdata),
    .t_raddr0(t_raddr0), .t_raddr1(t_raddr1), .t_rdata0(t_rdata0), .t_rdata1(t_rdata1)
  );

endmodule

`default_nettype wire
